@@ hdl/fcsr_pkg.sv @@
`timescale 1ns / 1ps

package fcsr_pkg;

    // One input item: a received link byte or a millisecond tick.
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic        reply_nak;
        logic [15:0] reply_seq;
        logic        transfer_done;
        logic [31:0] bytes_received;
    } t_out_item;

    // Receive phases, in the order the link walks through them.
    typedef enum logic [3:0] {
        PH_HDR_S   = 4'd0,
        PH_HDR_Z   = 4'd1,
        PH_SIZE    = 4'd2,
        PH_SOF0    = 4'd3,
        PH_SOF1    = 4'd4,
        PH_SEQ_LO  = 4'd5,
        PH_SEQ_HI  = 4'd6,
        PH_LEN_LO  = 4'd7,
        PH_LEN_HI  = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_CRC_LO  = 4'd10,
        PH_CRC_HI  = 4'd11
    } t_phase;

    // Event codes of a result item.
    localparam logic [2:0] EV_DATA   = 3'd0;
    localparam logic [2:0] EV_HDRACK = 3'd1;
    localparam logic [2:0] EV_ACCEPT = 3'd2;
    localparam logic [2:0] EV_NAK    = 3'd3;
    localparam logic [2:0] EV_DROP   = 3'd4;

    // Mode codes of an input item.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Framing bytes and CRC constants.
    localparam logic [7:0]  HDR_BYTE_S   = 8'h53;
    localparam logic [7:0]  HDR_BYTE_Z   = 8'h5A;
    localparam logic [7:0]  SOF_BYTE_0   = 8'h55;
    localparam logic [7:0]  SOF_BYTE_1   = 8'hAA;
    localparam logic [7:0]  ACK_BYTE     = 8'h06;
    localparam logic [7:0]  NAK_BYTE     = 8'h15;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RST  = 16'd2500;

    // CRC16-CCITT update by one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/framed_crc_stream_receiver_top.sv @@
`timescale 1ns / 1ps

// Framed CRC stream receiver.
// Input channel (i_in_valid, i_in_data, o_in_stall): each item is either a
// received link byte or a millisecond tick. The block first finds the header
// 'S','Z' plus a 32-bit little-endian size, then deframes 0x55 0xAA frames
// with sequence, length, payload and CRC16-CCITT, and reports payload bytes,
// header ACK, frame ACK, NAK and silent drops as result items.
// Output channel (o_out_valid, o_out_data, i_out_stall): zero or one result
// per input item, in input order. Configuration channel (i_cfg_valid,
// i_cfg_data, o_cfg_ready) writes the per-phase timeout in ticks; it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. Each result is registered in the
// output register. Throughput: one item per cycle while the input channel is
// not stalled, set by a state update that includes the byte-wide CRC step.
// A stalled output is held in the output register; one more result fits in
// a skid register, after which the input channel is stalled until the
// receiver takes an item. Synchronous reset returns the block to header
// search, empties both registers and sets the timeout to 2500 ticks.
module framed_crc_stream_receiver_top #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fcsr_pkg::t_in_item  i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output fcsr_pkg::t_out_item o_out_data,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    output logic              o_cfg_ready
);
    import fcsr_pkg::*;

    localparam int          LW     = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    // State registers.
    t_phase       r_phase,    n_phase;
    logic [31:0]  r_size,     n_size;
    logic [1:0]   r_size_idx, n_size_idx;
    logic [31:0]  r_exp_size, n_exp_size;
    logic [31:0]  r_acc,      n_acc;
    logic [15:0]  r_exp_seq,  n_exp_seq;
    logic [15:0]  r_seq,      n_seq;
    logic [7:0]   r_len_lo,   n_len_lo;
    logic [LW-1:0] r_flen,    n_flen;
    logic [LW-1:0] r_bidx,    n_bidx;
    logic [15:0]  r_crc,      n_crc;
    logic [7:0]   r_crc_lo,   n_crc_lo;
    logic [15:0]  r_wait,     n_wait;
    logic [15:0]  r_timeout;

    // Output and skid registers.
    logic         r_out_valid;
    t_out_item    r_out;
    logic         r_skid_valid;
    t_out_item    r_skid;

    // Decoded item and shared terms.
    logic         in_fire;
    logic         is_tick;
    logic [7:0]   rxb;
    logic         tick_phase;
    logic [15:0]  wc_next;
    logic         timeout_hit;
    logic [31:0]  size_final;
    logic         size_last;
    logic [15:0]  len16;
    logic         len_bad;
    logic [15:0]  rx_crc;
    logic         frame_bad;
    logic [32:0]  acc_sum;
    logic [31:0]  acc_new;
    logic         xfer_done;
    logic [LW-1:0] bidx_inc;
    logic         payload_last;
    logic         out_fire;

    // Result of the current item.
    logic         res_valid;
    t_out_item    res;

    assign in_fire      = i_in_valid && !r_skid_valid;
    assign is_tick      = (i_in_data.mode == MODE_TICK);
    assign rxb          = i_in_data.rx_byte;
    assign tick_phase   = (r_phase >= PH_SOF0) && (r_phase <= PH_CRC_HI);
    assign wc_next      = r_wait + 16'd1;
    assign timeout_hit  = (wc_next >= r_timeout);
    assign size_final   = {rxb, r_size[31:8]};
    assign size_last    = (r_size_idx == 2'd3);
    assign len16        = {rxb, r_len_lo};
    assign len_bad      = (len16 == 16'd0) || (len16 > MaxLen);
    assign rx_crc       = {rxb, r_crc_lo};
    assign frame_bad    = (rx_crc != r_crc) || (r_seq != r_exp_seq);
    assign acc_sum      = {1'b0, r_acc} + 33'(r_flen);
    assign acc_new      = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    assign xfer_done    = (acc_new >= r_exp_size);
    assign bidx_inc     = r_bidx + LW'(1);
    assign payload_last = (bidx_inc >= r_flen);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (in_fire) begin
            if (is_tick) begin
                if (tick_phase && timeout_hit) begin
                    n_phase = PH_SOF0;
                end
            end else begin
                unique case (r_phase)
                    PH_HDR_S:   n_phase = (rxb == HDR_BYTE_S) ? PH_HDR_Z : PH_HDR_S;
                    PH_HDR_Z:   n_phase = (rxb == HDR_BYTE_Z) ? PH_SIZE : PH_HDR_S;
                    PH_SIZE: begin
                        if (size_last) begin
                            n_phase = (size_final == 32'd0) ? PH_HDR_S : PH_SOF0;
                        end
                    end
                    PH_SOF0: begin
                        if (rxb == SOF_BYTE_0) begin
                            n_phase = PH_SOF1;
                        end
                    end
                    PH_SOF1:    n_phase = (rxb != SOF_BYTE_1) ? PH_SOF0 : PH_SEQ_LO;
                    PH_SEQ_LO:  n_phase = PH_SEQ_HI;
                    PH_SEQ_HI:  n_phase = PH_LEN_LO;
                    PH_LEN_LO:  n_phase = PH_LEN_HI;
                    PH_LEN_HI:  n_phase = len_bad ? PH_SOF0 : PH_PAYLOAD;
                    PH_PAYLOAD: begin
                        if (payload_last) begin
                            n_phase = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO:  n_phase = PH_CRC_HI;
                    PH_CRC_HI: begin
                        if (frame_bad || !xfer_done) begin
                            n_phase = PH_SOF0;
                        end else begin
                            n_phase = PH_HDR_S;
                        end
                    end
                    default:    n_phase = PH_HDR_S;
                endcase
            end
        end
    end

    // Next datapath state.
    always_comb begin
        n_size     = r_size;
        n_size_idx = r_size_idx;
        n_exp_size = r_exp_size;
        n_acc      = r_acc;
        n_exp_seq  = r_exp_seq;
        n_seq      = r_seq;
        n_len_lo   = r_len_lo;
        n_flen     = r_flen;
        n_bidx     = r_bidx;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_wait     = r_wait;
        if (in_fire) begin
            if (is_tick) begin
                if (tick_phase) begin
                    n_wait = timeout_hit ? 16'd0 : wc_next;
                end
            end else begin
                unique case (r_phase)
                    PH_HDR_S: begin
                    end
                    PH_HDR_Z: begin
                        n_size     = 32'd0;
                        n_size_idx = 2'd0;
                    end
                    PH_SIZE: begin
                        n_size     = size_final;
                        n_size_idx = r_size_idx + 2'd1;
                        if (size_last) begin
                            n_exp_size = size_final;
                            n_acc      = 32'd0;
                            n_exp_seq  = 16'd0;
                            if (size_final != 32'd0) begin
                                n_wait = 16'd0;
                            end
                        end
                    end
                    PH_SOF0: n_wait = 16'd0;
                    PH_SOF1: n_wait = 16'd0;
                    PH_SEQ_LO: n_seq = {8'd0, rxb};
                    PH_SEQ_HI: n_seq = {rxb, r_seq[7:0]};
                    PH_LEN_LO: n_len_lo = rxb;
                    PH_LEN_HI: begin
                        n_wait = 16'd0;
                        if (!len_bad) begin
                            n_flen = LW'(len16);
                            n_bidx = '0;
                            n_crc  = CRC_INIT;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_crc  = crc16_byte(r_crc, rxb);
                        n_bidx = bidx_inc;
                        if (payload_last) begin
                            n_wait = 16'd0;
                        end
                    end
                    PH_CRC_LO: n_crc_lo = rxb;
                    PH_CRC_HI: begin
                        n_wait = 16'd0;
                        if (!frame_bad) begin
                            n_acc     = acc_new;
                            n_exp_seq = r_exp_seq + 16'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result of the accepted item.
    always_comb begin
        res_valid          = 1'b0;
        res                = '0;
        res.bytes_received = n_acc;
        if (in_fire) begin
            if (is_tick) begin
                if (tick_phase && timeout_hit) begin
                    res_valid     = 1'b1;
                    res.event_res = EV_DROP;
                end
            end else begin
                unique case (r_phase)
                    PH_SIZE: begin
                        if (size_last) begin
                            res_valid         = 1'b1;
                            res.event_res     = EV_HDRACK;
                            res.transfer_done = (size_final == 32'd0);
                        end
                    end
                    PH_SOF1: begin
                        if (rxb != SOF_BYTE_1) begin
                            res_valid     = 1'b1;
                            res.event_res = EV_DROP;
                        end
                    end
                    PH_LEN_HI: begin
                        if (len_bad) begin
                            res_valid     = 1'b1;
                            res.event_res = EV_DROP;
                        end
                    end
                    PH_PAYLOAD: begin
                        res_valid     = 1'b1;
                        res.event_res = EV_DATA;
                        res.data_byte = rxb;
                    end
                    PH_CRC_HI: begin
                        res_valid     = 1'b1;
                        res.reply_seq = r_seq;
                        if (frame_bad) begin
                            res.event_res = EV_NAK;
                            res.reply_nak = 1'b1;
                        end else begin
                            res.event_res     = EV_ACCEPT;
                            res.transfer_done = xfer_done;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // State update and timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR_S;
            r_size     <= '0;
            r_size_idx <= '0;
            r_exp_size <= '0;
            r_acc      <= '0;
            r_exp_seq  <= '0;
            r_seq      <= '0;
            r_len_lo   <= '0;
            r_flen     <= '0;
            r_bidx     <= '0;
            r_crc      <= CRC_INIT;
            r_crc_lo   <= '0;
            r_wait     <= '0;
            r_timeout  <= TIMEOUT_RST;
        end else begin
            r_phase    <= n_phase;
            r_size     <= n_size;
            r_size_idx <= n_size_idx;
            r_exp_size <= n_exp_size;
            r_acc      <= n_acc;
            r_exp_seq  <= n_exp_seq;
            r_seq      <= n_seq;
            r_len_lo   <= n_len_lo;
            r_flen     <= n_flen;
            r_bidx     <= n_bidx;
            r_crc      <= n_crc;
            r_crc_lo   <= n_crc_lo;
            r_wait     <= n_wait;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Output register with a skid register behind it.
    assign out_fire = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ hdl/fcsr_checker.sv @@
`timescale 1ns / 1ps

module fcsr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input fcsr_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);
    import fcsr_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // Only the five defined events are ever reported.
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_res == EV_DATA ||
                         o_out_data.event_res == EV_HDRACK ||
                         o_out_data.event_res == EV_ACCEPT ||
                         o_out_data.event_res == EV_NAK ||
                         o_out_data.event_res == EV_DROP))
        else $error("undefined event code");

    // The NAK flag goes with the NAK event and nothing else.
    a_nak_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.reply_nak == (o_out_data.event_res == EV_NAK)))
        else $error("reply code disagrees with event");

    // Data byte is zero unless the item carries payload.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_res != EV_DATA) |->
            (o_out_data.data_byte == 8'd0))
        else $error("data byte set on a non-payload event");

endmodule

bind framed_crc_stream_receiver_top fcsr_checker u_fcsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

@@ bench/framed_crc_stream_receiver_top_test.sv @@
`timescale 1ns / 1ps

module framed_crc_stream_receiver_top_test;

    import fcsr_pkg::*;

    localparam int FRAME_MAX = 256;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        ROW_MODEL = 2'd0,
        ROW_QUIET = 2'd1,
        ROW_TYPED = 2'd2
    } t_row_kind;

    // Frame flavors used by the random traffic.
    typedef enum logic [2:0] {
        FR_GOOD    = 3'd0,
        FR_BAD_CRC = 3'd1,
        FR_BAD_SEQ = 3'd2,
        FR_BAD_SOF = 3'd3,
        FR_BAD_LEN = 3'd4,
        FR_STALL   = 3'd5
    } t_frame_kind;

    typedef struct packed {
        t_row_kind kind;
        t_in_item  item;
        t_out_item want;
    } t_directed_row;

    // One queued link item and the reply it is predicted to cause.
    typedef struct packed {
        t_in_item  item;
        logic      has;
        t_out_item want;
    } t_link_entry;

    localparam t_out_item NO_REPLY    = '0;
    localparam t_out_item HDR_DONE    = {EV_HDRACK, 8'h00, 1'b0, 16'h0000, 1'b1, 32'd0};
    localparam t_out_item HDR_OPEN    = {EV_HDRACK, 8'h00, 1'b0, 16'h0000, 1'b0, 32'd0};
    localparam t_out_item DROP_EMPTY  = {EV_DROP, 8'h00, 1'b0, 16'h0000, 1'b0, 32'd0};
    localparam t_out_item DATA_FF     = {EV_DATA, 8'hFF, 1'b0, 16'h0000, 1'b0, 32'd0};
    localparam t_out_item ACCEPT_DONE = {EV_ACCEPT, 8'h00, 1'b0, 16'h0000, 1'b1, 32'd1};

    localparam int DIRECTED_ROWS = 33;

    // Directed opening: header search corner cases, a zero size transfer, a
    // one byte transfer with a bad second SOF byte, an oversize length and
    // one good frame whose CRC over 0xFF is 0xFF00.
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        {ROW_QUIET, MODE_TICK, 8'hFF, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_S, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_S, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_Z, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_S, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_Z, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_TYPED, MODE_BYTE, 8'h00, HDR_DONE},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_S, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, HDR_BYTE_Z, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, 8'h01, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_QUIET, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_TYPED, MODE_BYTE, 8'h00, HDR_OPEN},
        {ROW_MODEL, MODE_BYTE, SOF_BYTE_0, NO_REPLY},
        {ROW_TYPED, MODE_BYTE, SOF_BYTE_0, DROP_EMPTY},
        {ROW_MODEL, MODE_BYTE, SOF_BYTE_0, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, SOF_BYTE_1, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h01, NO_REPLY},
        {ROW_TYPED, MODE_BYTE, 8'h01, DROP_EMPTY},
        {ROW_MODEL, MODE_BYTE, SOF_BYTE_0, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, SOF_BYTE_1, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h01, NO_REPLY},
        {ROW_MODEL, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_TYPED, MODE_BYTE, 8'hFF, DATA_FF},
        {ROW_MODEL, MODE_BYTE, 8'h00, NO_REPLY},
        {ROW_TYPED, MODE_BYTE, 8'hFF, ACCEPT_DONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_cfg_ready;

    // Receiver state as the predictor sees it.
    t_phase      rx_phase;
    logic [31:0] size_acc;
    logic [8:0]  pos;
    logic [31:0] size_goal;
    logic [31:0] good_bytes;
    logic [15:0] seq_want;
    logic [15:0] seq_got;
    logic [8:0]  len_got;
    logic [15:0] crc_run;
    logic [7:0]  crc_lo;
    logic [15:0] tick_count;
    logic [15:0] tick_limit;

    t_link_entry link_items[$];
    t_out_item   pending_replies[$];
    t_link_entry held;
    int          fed_count;
    int          fault_count = 0;
    bit          calm = 1'b0;

    framed_crc_stream_receiver_top #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready)
    );

    always #6 i_clk = ~i_clk;

    // CRC16-CCITT, one input bit at a time, MSB first.
    function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void move_to(input t_phase p);
        rx_phase = p;
        tick_count = '0;
    endfunction

    function automatic void rx_reset();
        tick_limit = TIMEOUT_RST;
        rx_phase = PH_HDR_S;
        size_acc = '0;
        pos = '0;
        size_goal = '0;
        good_bytes = '0;
        seq_want = '0;
        seq_got = '0;
        len_got = '0;
        crc_run = CRC_INIT;
        crc_lo = '0;
        tick_count = '0;
    endfunction

    // Advances the receiver by one link item; returns 1 when it replies.
    function automatic logic predict_rx_item(input t_in_item it, output t_out_item res);
        logic [15:0] nxt_tick;
        logic [15:0] len16;
        logic [15:0] crc_rx;
        logic [32:0] sum;
        logic [7:0]  b;
        logic        has;
        b = it.rx_byte;
        res = '0;
        has = 1'b0;
        if (it.mode == MODE_TICK) begin
            // Ticks only matter once framing has started.
            if (rx_phase >= PH_SOF0) begin
                nxt_tick = tick_count + 16'd1;
                if (nxt_tick >= tick_limit) begin
                    move_to(PH_SOF0);
                    res.event_res = EV_DROP;
                    has = 1'b1;
                end else begin
                    tick_count = nxt_tick;
                end
            end
        end else begin
            unique case (rx_phase)
                PH_HDR_S: begin
                    rx_phase = (b == HDR_BYTE_S) ? PH_HDR_Z : PH_HDR_S;
                end
                PH_HDR_Z: begin
                    pos = '0;
                    size_acc = '0;
                    rx_phase = (b == HDR_BYTE_Z) ? PH_SIZE : PH_HDR_S;
                end
                PH_SIZE: begin
                    size_acc = size_acc | (32'(b) << (8 * pos[1:0]));
                    pos = pos + 9'd1;
                    if (pos >= 9'd4) begin
                        pos = '0;
                        size_goal = size_acc;
                        good_bytes = '0;
                        seq_want = '0;
                        res.event_res = EV_HDRACK;
                        has = 1'b1;
                        if (size_goal == 32'd0) begin
                            rx_phase = PH_HDR_S;
                            res.transfer_done = 1'b1;
                        end else begin
                            move_to(PH_SOF0);
                        end
                    end
                end
                PH_SOF0: begin
                    tick_count = '0;
                    if (b == SOF_BYTE_0) begin
                        move_to(PH_SOF1);
                    end
                end
                PH_SOF1: begin
                    if (b != SOF_BYTE_1) begin
                        move_to(PH_SOF0);
                        res.event_res = EV_DROP;
                        has = 1'b1;
                    end else begin
                        move_to(PH_SEQ_LO);
                    end
                end
                PH_SEQ_LO: begin
                    seq_got = {8'h00, b};
                    rx_phase = PH_SEQ_HI;
                end
                PH_SEQ_HI: begin
                    seq_got[15:8] = b;
                    rx_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_got = {1'b0, b};
                    rx_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len16 = {b, len_got[7:0]};
                    if (len16 == 16'd0 || len16 > 16'(FRAME_MAX)) begin
                        move_to(PH_SOF0);
                        res.event_res = EV_DROP;
                        has = 1'b1;
                    end else begin
                        len_got = len16[8:0];
                        pos = '0;
                        crc_run = CRC_INIT;
                        move_to(PH_PAYLOAD);
                    end
                end
                PH_PAYLOAD: begin
                    crc_run = ccitt_next(crc_run, b);
                    pos = pos + 9'd1;
                    if (pos >= len_got) begin
                        move_to(PH_CRC_LO);
                    end
                    res.event_res = EV_DATA;
                    res.data_byte = b;
                    has = 1'b1;
                end
                PH_CRC_LO: begin
                    crc_lo = b;
                    rx_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    crc_rx = {b, crc_lo};
                    move_to(PH_SOF0);
                    res.reply_seq = seq_got;
                    has = 1'b1;
                    if (crc_rx != crc_run || seq_got != seq_want) begin
                        res.event_res = EV_NAK;
                        res.reply_nak = 1'b1;
                    end else begin
                        // The accepted total saturates instead of wrapping.
                        sum = {1'b0, good_bytes} + 33'(len_got);
                        good_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        seq_want = seq_want + 16'd1;
                        res.event_res = EV_ACCEPT;
                        if (good_bytes >= size_goal) begin
                            rx_phase = PH_HDR_S;
                            res.transfer_done = 1'b1;
                        end
                    end
                end
                default: begin
                    rx_phase = PH_HDR_S;
                end
            endcase
        end
        res.bytes_received = good_bytes;
        return has;
    endfunction

    function automatic void note_fault(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // Queues one item and records the reply it should cause.
    task automatic queue_item(input logic mode, input logic [7:0] b);
        t_link_entry e;
        e.item.mode = mode;
        e.item.rx_byte = b;
        if (!(mode == MODE_TICK && rx_phase < PH_SOF0)) begin
            fed_count++;
        end
        e.has = predict_rx_item(e.item, e.want);
        link_items.push_back(e);
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 99) < 30) begin
                queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) < 15) begin
                queue_item(MODE_BYTE, HDR_BYTE_S);
            end else begin
                queue_item(MODE_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Builds one frame of the given flavor, with stray ticks that stay under
    // the timeout, and queues it.
    task automatic queue_frame(input t_frame_kind kind);
        logic [7:0]  body[$];
        logic [7:0]  d;
        logic [15:0] seq;
        logic [15:0] len;
        logic [15:0] crc;
        int          roll;
        int          cut;
        seq = seq_want;
        if (kind == FR_BAD_SEQ) begin
            seq = seq_want + 16'($urandom_range(1, 65535));
        end
        roll = $urandom_range(0, 99);
        if (kind == FR_BAD_LEN) begin
            len = (roll < 50) ? 16'd0 : 16'($urandom_range(FRAME_MAX + 1, 65535));
        end else if (roll < 90) begin
            len = 16'($urandom_range(1, 8));
        end else if (roll < 98) begin
            len = 16'($urandom_range(9, 64));
        end else begin
            len = 16'(FRAME_MAX);
        end
        body.push_back(SOF_BYTE_0);
        if (kind == FR_BAD_SOF) begin
            // Half the time the bad byte is another 0x55, which is consumed.
            if ($urandom_range(0, 1) == 0) begin
                d = SOF_BYTE_0;
            end else begin
                do d = 8'($urandom_range(0, 255)); while (d == SOF_BYTE_1);
            end
            body.push_back(d);
        end else begin
            body.push_back(SOF_BYTE_1);
            body.push_back(seq[7:0]);
            body.push_back(seq[15:8]);
            body.push_back(len[7:0]);
            body.push_back(len[15:8]);
            if (kind != FR_BAD_LEN) begin
                crc = CRC_INIT;
                for (int i = 0; i < int'(len); i++) begin
                    d = 8'($urandom_range(0, 255));
                    crc = ccitt_next(crc, d);
                    body.push_back(d);
                end
                if (kind == FR_BAD_CRC) begin
                    crc = crc ^ (16'd1 << $urandom_range(0, 15));
                end
                body.push_back(crc[7:0]);
                body.push_back(crc[15:8]);
            end
        end
        cut = (kind == FR_STALL) ? $urandom_range(1, body.size() - 1) : body.size();
        for (int i = 0; i < cut; i++) begin
            if (i > 0 && $urandom_range(0, 99) < 4 &&
                ({1'b0, tick_count} + 17'd1) < {1'b0, tick_limit}) begin
                queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
            end
            queue_item(MODE_BYTE, body[i]);
        end
        // A truncated frame is left to run out of time.
        if (kind == FR_STALL) begin
            while (rx_phase != PH_SOF0) begin
                queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // One random step: a header (at times after noise) while searching, otherwise a frame or noise.
    task automatic feed_random();
        int          roll;
        logic [31:0] goal;
        roll = $urandom_range(0, 99);
        if (rx_phase < PH_SOF0) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_noise();
            end
            if (roll < 10) begin
                goal = '0;
            end else if (roll < 95) begin
                goal = $urandom_range(1, 48);
            end else begin
                goal = $urandom_range(200, 700);
            end
            queue_item(MODE_BYTE, HDR_BYTE_S);
            queue_item(MODE_BYTE, HDR_BYTE_Z);
            for (int k = 0; k < 4; k++) begin
                queue_item(MODE_BYTE, goal[8*k +: 8]);
            end
        end else if (roll < 68) begin
            queue_frame(FR_GOOD);
        end else if (roll < 76) begin
            queue_frame(FR_BAD_CRC);
        end else if (roll < 82) begin
            queue_frame(FR_BAD_SEQ);
        end else if (roll < 87) begin
            queue_frame(FR_BAD_SOF);
        end else if (roll < 92) begin
            queue_frame(FR_BAD_LEN);
        end else if (roll < 96) begin
            queue_frame((tick_limit <= 16'd64) ? FR_STALL : FR_GOOD);
        end else begin
            queue_noise();
        end
    endtask

    // Waits until every queued item is taken and every reply has arrived.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (link_items.size() != 0 || i_in_valid || pending_replies.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n);
        fed_count = 0;
        while (fed_count < n) begin
            feed_random();
        end
        wait_drained();
    endtask

    task automatic write_timeout(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tick_limit = value;
        @(negedge i_clk);
    endtask

    // Output check, input handshake, item driving and output stall, all at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        logic      take;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    note_fault("unexpected result, event_res", '0,
                               32'(o_out_data.event_res));
                end else begin
                    want = pending_replies.pop_front();
                    if (o_out_data.event_res !== want.event_res) begin
                        note_fault("event_res", 32'(want.event_res),
                                   32'(o_out_data.event_res));
                    end
                    if (o_out_data.data_byte !== want.data_byte) begin
                        note_fault("data_byte", 32'(want.data_byte),
                                   32'(o_out_data.data_byte));
                    end
                    if (o_out_data.reply_nak !== want.reply_nak) begin
                        note_fault("reply_nak", 32'(want.reply_nak),
                                   32'(o_out_data.reply_nak));
                    end
                    if (o_out_data.reply_seq !== want.reply_seq) begin
                        note_fault("reply_seq", 32'(want.reply_seq),
                                   32'(o_out_data.reply_seq));
                    end
                    if (o_out_data.transfer_done !== want.transfer_done) begin
                        note_fault("transfer_done", 32'(want.transfer_done),
                                   32'(o_out_data.transfer_done));
                    end
                    if (o_out_data.bytes_received !== want.bytes_received) begin
                        note_fault("bytes_received", want.bytes_received,
                                   o_out_data.bytes_received);
                    end
                end
            end

            take = i_in_valid && !o_in_stall;
            if (take && held.has) begin
                pending_replies.push_back(held.want);
            end

            // A held item stays put until taken; a new one may be held back at random.
            if (take || !i_in_valid) begin
                if (link_items.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
                    held = link_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data <= held.item;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < 9);
        end
    end

    // Run limit.
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_link_entry e;
        t_out_item   model_res;
        logic        model_has;
        rx_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows at the reset timeout.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            e.item = DIRECTED[r].item;
            model_has = predict_rx_item(e.item, model_res);
            unique case (DIRECTED[r].kind)
                ROW_TYPED: begin
                    e.has = 1'b1;
                    e.want = DIRECTED[r].want;
                end
                ROW_QUIET: begin
                    e.has = 1'b0;
                    e.want = NO_REPLY;
                end
                default: begin
                    e.has = model_has;
                    e.want = model_res;
                end
            endcase
            link_items.push_back(e);
        end
        run_phase(100);

        // Shortest timeout, then zero, which acts as one tick.
        write_timeout(16'd1);
        run_phase(120);
        write_timeout(16'd0);
        run_phase(60);

        // Longest timeout with both sides streaming without gaps.
        write_timeout(16'hFFFF);
        calm = 1'b1;
        run_phase(100);
        calm = 1'b0;

        // A short random timeout, with a full drain in the middle.
        write_timeout(16'($urandom_range(2, 40)));
        run_phase(110);
        run_phase(110);

        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/fcsr_pkg.sv
hdl/framed_crc_stream_receiver_top.sv
hdl/fcsr_checker.sv
bench/framed_crc_stream_receiver_top_test.sv
